@@ sv/gds_pkg.sv @@
// gds_pkg: widths, word records and rounding helpers for the gaussian density series
// no dependencies; imported by gaussian_density_series
`default_nettype none

package gds_pkg;

    localparam int FRAC_BITS = 32;
    localparam int TERMS_DEF = 32;

    localparam int X_W     = 16;
    localparam int DENS_W  = 15;
    localparam int X_LIMIT = 16384;
    localparam int XM_W    = 15;
    localparam int SQ_W    = 2 * XM_W;
    localparam int SQ_FRAC = 25;

    localparam int TM_W   = FRAC_BITS + 4;
    localparam int MAG_W  = FRAC_BITS + 9;
    localparam int P_W    = FRAC_BITS + 12;
    localparam int RCP_W  = FRAC_BITS + 1;
    localparam int SUM_W  = FRAC_BITS + 14;
    localparam int E_W    = FRAC_BITS + 1;

    localparam int T_LO_W = (TM_W + 1) / 2;
    localparam int T_HI_W = TM_W - T_LO_W;
    localparam int R_LO_W = (RCP_W + 1) / 2;
    localparam int R_HI_W = RCP_W - R_LO_W;

    localparam int C_W    = 32;
    localparam logic [C_W-1:0] INV_SQRT_2PI = 32'd1713444047;
    localparam int PRD_W  = E_W + C_W;
    localparam int DEN_SH = FRAC_BITS + 16;
    localparam int DRAW_W = PRD_W + 1 - DEN_SH;

    localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << FRAC_BITS;
    localparam logic [E_W-1:0]   ONE_E   = E_W'(1) << FRAC_BITS;
    localparam logic [DENS_W-1:0] DENS_MAX = '1;

    typedef struct packed {
        logic                    flag;
        logic [TM_W-1:0]         tm;
        logic signed [SUM_W-1:0] sum;
        logic [MAG_W-1:0]        mag;
    } term_t;

    typedef struct packed {
        logic                      flag;
        logic [TM_W-1:0]           tm;
        logic signed [SUM_W-1:0]   sum;
        logic [MAG_W+T_HI_W-1:0]   ph;
        logic [MAG_W+T_LO_W-1:0]   pl;
    } a_t;

    typedef struct packed {
        logic                    flag;
        logic [TM_W-1:0]         tm;
        logic signed [SUM_W-1:0] sum;
        logic [P_W-1:0]          p;
    } b_t;

    typedef struct packed {
        logic                    flag;
        logic [TM_W-1:0]         tm;
        logic signed [SUM_W-1:0] sum;
        logic [P_W+R_HI_W-1:0]   qh;
        logic [P_W+R_LO_W-1:0]   ql;
    } c_t;

    // join the two partial products of term * t, round half up, drop the fraction
    function automatic logic [P_W-1:0] join_t(input logic [MAG_W+T_HI_W-1:0] ph,
                                              input logic [MAG_W+T_LO_W-1:0] pl);
        logic [MAG_W+TM_W:0] s;
        s = {1'b0, ph, {T_LO_W{1'b0}}} + (MAG_W+TM_W+1)'(pl)
            + ((MAG_W+TM_W+1)'(1) << (FRAC_BITS - 1));
        return s[FRAC_BITS +: P_W];
    endfunction

    // join the two partial products of p * 1/i, round half up, drop the fraction
    function automatic logic [MAG_W-1:0] join_r(input logic [P_W+R_HI_W-1:0] qh,
                                                input logic [P_W+R_LO_W-1:0] ql);
        logic [P_W+RCP_W:0] s;
        s = {1'b0, qh, {R_LO_W{1'b0}}} + (P_W+RCP_W+1)'(ql)
            + ((P_W+RCP_W+1)'(1) << (FRAC_BITS - 1));
        return s[FRAC_BITS +: MAG_W];
    endfunction

endpackage

`default_nettype wire

@@ sv/gaussian_density_series.sv @@
// gaussian_density_series: pipelined standard normal density by truncated exp series
// depends on gds_pkg
`default_nettype none

// Takes one signed Q4.12 word x per cycle and returns phi(x) in unsigned Q0.16 with a flag
// set when |x| > 4 was clamped to +-4. A word goes through 4*TERMS+1 register stages: two front
// stages clamp and square x, each series term takes four stages (split multiply by t, round,
// split multiply by 1/i, round) and three back stages finish the sum, scale by
// 1/sqrt(2*pi) and round. One word is accepted every cycle while the skid stage is empty; a
// two-entry output register and skid stage hold results while out_ready is low, and in_ready
// drops only while the skid stage is full.
module gaussian_density_series #(
    parameter int TERMS = gds_pkg::TERMS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [gds_pkg::X_W-1:0]     x_in,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [gds_pkg::DENS_W-1:0]       density,
    output logic                             clamped
);
    import gds_pkg::*;

    localparam bit NEG_LAST = ((TERMS - 1) % 2) == 1;

    logic en;
    logic skid_valid_reg, skid_valid_next;

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    // front: clamp
    logic                    vx_reg;
    logic [XM_W-1:0]         xm_reg, xm_next;
    logic                    fx_reg, fx_next;
    logic signed [X_W-1:0]   xs;
    logic [X_W-1:0]          xabs;

    always_comb
    begin
        xs      = $signed(x_in);
        fx_next = (xs > $signed(X_W'(X_LIMIT))) || (xs < -$signed(X_W'(X_LIMIT)));
        xabs    = xs[X_W-1] ? X_W'(-xs) : X_W'(xs);
        xm_next = fx_next ? XM_W'(X_LIMIT) : xabs[XM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vx_reg <= 1'b0;
        else if (en)
            vx_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xm_reg <= xm_next;
            fx_reg <= fx_next;
        end
    end

    // front: square into t magnitude, seed term zero
    term_t           d_q [0:TERMS-1];
    logic            vd_q [0:TERMS-1];
    logic            v0_reg;
    term_t           d0_reg, d0_next;
    logic [SQ_W-1:0] sq;
    logic [TM_W-1:0] tm;

    assign sq = SQ_W'(xm_reg) * SQ_W'(xm_reg);

    if (FRAC_BITS >= SQ_FRAC)
    begin : g_tm_up
        assign tm = TM_W'(sq) << (FRAC_BITS - SQ_FRAC);
    end
    else
    begin : g_tm_dn
        localparam int SH = SQ_FRAC - FRAC_BITS;
        logic [SQ_W:0] sqr;
        assign sqr = {1'b0, sq} + ((SQ_W+1)'(1) << (SH - 1));
        assign tm  = TM_W'(sqr >> SH);
    end

    always_comb
    begin
        d0_next.flag = fx_reg;
        d0_next.tm   = tm;
        d0_next.sum  = '0;
        d0_next.mag  = ONE_MAG;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= vx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d0_reg <= d0_next;
    end

    assign d_q[0]  = d0_reg;
    assign vd_q[0] = v0_reg;

    // series terms, four stages each
    for (genvar i = 1; i < TERMS; i++)
    begin : g_term
        localparam logic [RCP_W-1:0] RCP =
            RCP_W'(((65'(1) << FRAC_BITS) + 65'(i / 2)) / 65'(i));
        localparam bit NEG = (i % 2) == 0;

        logic  va_reg, vb_reg, vc_reg, vd_reg;
        a_t    a_reg, a_next;
        b_t    b_reg, b_next;
        c_t    c_reg, c_next;
        term_t d_reg, d_next;
        logic signed [SUM_W-1:0] magx;

        always_comb
        begin
            magx        = $signed({{(SUM_W-MAG_W){1'b0}}, d_q[i-1].mag});
            a_next.flag = d_q[i-1].flag;
            a_next.tm   = d_q[i-1].tm;
            a_next.sum  = NEG ? d_q[i-1].sum - magx : d_q[i-1].sum + magx;
            a_next.pl   = (MAG_W+T_LO_W)'(d_q[i-1].mag)
                          * (MAG_W+T_LO_W)'(d_q[i-1].tm[T_LO_W-1:0]);
            a_next.ph   = (MAG_W+T_HI_W)'(d_q[i-1].mag)
                          * (MAG_W+T_HI_W)'(d_q[i-1].tm[TM_W-1:T_LO_W]);

            b_next.flag = a_reg.flag;
            b_next.tm   = a_reg.tm;
            b_next.sum  = a_reg.sum;
            b_next.p    = join_t(a_reg.ph, a_reg.pl);

            c_next.flag = b_reg.flag;
            c_next.tm   = b_reg.tm;
            c_next.sum  = b_reg.sum;
            c_next.ql   = (P_W+R_LO_W)'(b_reg.p) * (P_W+R_LO_W)'(RCP[R_LO_W-1:0]);
            c_next.qh   = (P_W+R_HI_W)'(b_reg.p) * (P_W+R_HI_W)'(RCP[RCP_W-1:R_LO_W]);

            d_next.flag = c_reg.flag;
            d_next.tm   = c_reg.tm;
            d_next.sum  = c_reg.sum;
            d_next.mag  = join_r(c_reg.qh, c_reg.ql);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg <= 1'b0;
                vb_reg <= 1'b0;
                vc_reg <= 1'b0;
                vd_reg <= 1'b0;
            end
            else if (en)
            begin
                va_reg <= vd_q[i-1];
                vb_reg <= va_reg;
                vc_reg <= vb_reg;
                vd_reg <= vc_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_reg <= a_next;
                b_reg <= b_next;
                c_reg <= c_next;
                d_reg <= d_next;
            end
        end

        assign d_q[i]  = d_reg;
        assign vd_q[i] = vd_reg;
    end

    // back: last sum and clamp to [0, 1]
    logic                    vs_reg;
    logic [E_W-1:0]          e_reg, e_next;
    logic                    fs_reg;
    logic signed [SUM_W-1:0] lastx, sum_f;

    always_comb
    begin
        lastx = $signed({{(SUM_W-MAG_W){1'b0}}, d_q[TERMS-1].mag});
        sum_f = NEG_LAST ? d_q[TERMS-1].sum - lastx : d_q[TERMS-1].sum + lastx;
        if (sum_f[SUM_W-1])
            e_next = '0;
        else if (sum_f > $signed(SUM_W'(ONE_E)))
            e_next = ONE_E;
        else
            e_next = sum_f[E_W-1:0];
    end

    // back: scale
    logic             vm_reg;
    logic [PRD_W-1:0] prd_reg, prd_next;
    logic             fm_reg;

    assign prd_next = PRD_W'(e_reg) * PRD_W'(INV_SQRT_2PI);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vs_reg <= 1'b0;
            vm_reg <= 1'b0;
        end
        else if (en)
        begin
            vs_reg <= vd_q[TERMS-1];
            vm_reg <= vs_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg   <= e_next;
            fs_reg  <= d_q[TERMS-1].flag;
            prd_reg <= prd_next;
            fm_reg  <= fs_reg;
        end
    end

    // back: round, saturate, output register and skid stage
    logic [PRD_W:0]      prd_r;
    logic [DRAW_W-1:0]   draw;
    logic [DENS_W-1:0]   fin_dens;

    always_comb
    begin
        prd_r    = {1'b0, prd_reg} + ((PRD_W+1)'(1) << (DEN_SH - 1));
        draw     = prd_r[DEN_SH +: DRAW_W];
        fin_dens = (draw > DRAW_W'(DENS_MAX)) ? DENS_MAX : draw[DENS_W-1:0];
    end

    logic              out_valid_reg, out_valid_next;
    logic [DENS_W-1:0] dens_reg, dens_next, skid_dens_reg, skid_dens_next;
    logic              flag_reg, flag_next, skid_flag_reg, skid_flag_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        dens_next       = dens_reg;
        flag_next       = flag_reg;
        skid_dens_next  = skid_dens_reg;
        skid_flag_next  = skid_flag_reg;
        if (en)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_valid_next = vm_reg;
                dens_next      = fin_dens;
                flag_next      = fm_reg;
            end
            else if (vm_reg)
            begin
                skid_valid_next = 1'b1;
                skid_dens_next  = fin_dens;
                skid_flag_next  = fm_reg;
            end
        end
        else if (out_ready)
        begin
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
            dens_next       = skid_dens_reg;
            flag_next       = skid_flag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dens_reg      <= dens_next;
        flag_reg      <= flag_next;
        skid_dens_reg <= skid_dens_next;
        skid_flag_reg <= skid_flag_next;
    end

    assign out_valid = out_valid_reg;
    assign density   = dens_reg;
    assign clamped   = flag_reg;

    // checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
        en && vm_reg && out_valid_reg && !out_ready |=> skid_valid_reg)
        else $error("finished word dropped while output stalled");

    a_dens_peak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> density <= DENS_W'(26145))
        else $error("density above the peak value");

    a_clamped_tail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clamped |-> density <= DENS_W'(15))
        else $error("clamped word with a large density");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> !skid_valid_reg && out_valid_reg)
        else $error("skid word not moved on when output taken");

endmodule

`default_nettype wire

@@ bench/gaussian_density_series_test.sv @@
// gaussian_density_series_test: self-checking bench for the pipelined normal density block
// drives x words through a directed table then random phases, predicts phi(x) bit for bit
// depends on gds_pkg and gaussian_density_series
module gaussian_density_series_test;

    timeunit 1ns;
    timeprecision 1ps;

    import gds_pkg::*;

    localparam int            FRAC          = gds_pkg::FRAC_BITS;
    localparam int            SERIES_TERMS  = gds_pkg::TERMS_DEF;
    localparam int            CLAMP_LIMIT   = 16384;
    localparam longint unsigned ROOT_TWO_PI_INV = 64'd1713444047;
    localparam logic [63:0]   DENS_CEIL     = 64'h7FFF;
    localparam int            RANDOM_PER_PHASE = 600;
    localparam int            HOLD_CYCLES   = 400;
    localparam int            DRAIN_CYCLES  = 200;

    typedef struct packed {
        logic [DENS_W-1:0] density;
        logic              clamped;
    } phi_word_t;

    typedef struct packed {
        logic [X_W-1:0]    x;
        logic              typed;
        logic [DENS_W-1:0] density;
        logic              clamped;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [X_W-1:0]    x_in;
    logic              out_valid;
    logic              out_ready;
    logic [DENS_W-1:0] density;
    logic              clamped;

    // values that go with the word on x_in while it is offered
    logic              cur_typed;
    logic [DENS_W-1:0] cur_density;
    logic              cur_clamped;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_asked;
    int unsigned hold_served;
    int unsigned hold_left;
    int unsigned error_count;

    phi_word_t phi_expected[$];
    phi_word_t got_word;
    phi_word_t want_word;

    stim_row_t directed_rows [0:19] = '{
        '{16'h0000, 1'b1, 15'd26145, 1'b0},
        '{16'h0001, 1'b1, 15'd26145, 1'b0},
        '{16'hFFFF, 1'b1, 15'd26145, 1'b0},
        '{16'h4000, 1'b0, 15'd0, 1'b0},
        '{16'hC000, 1'b0, 15'd0, 1'b0},
        '{16'h4001, 1'b0, 15'd0, 1'b0},
        '{16'hBFFF, 1'b0, 15'd0, 1'b0},
        '{16'h7FFF, 1'b0, 15'd0, 1'b0},
        '{16'h8000, 1'b0, 15'd0, 1'b0},
        '{16'h1000, 1'b0, 15'd0, 1'b0},
        '{16'hF000, 1'b0, 15'd0, 1'b0},
        '{16'h2000, 1'b0, 15'd0, 1'b0},
        '{16'hE000, 1'b0, 15'd0, 1'b0},
        '{16'h3FFF, 1'b0, 15'd0, 1'b0},
        '{16'hC001, 1'b0, 15'd0, 1'b0},
        '{16'h5555, 1'b0, 15'd0, 1'b0},
        '{16'hAAAA, 1'b0, 15'd0, 1'b0},
        '{16'h0800, 1'b0, 15'd0, 1'b0},
        '{16'h0FFF, 1'b0, 15'd0, 1'b0},
        '{16'h7000, 1'b0, 15'd0, 1'b0}
    };

    gaussian_density_series u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x_in      (x_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .density   (density),
        .clamped   (clamped)
    );

    // (a * b + half) >> sh on unsigned magnitudes, exact wide product
    function automatic logic [63:0] mul_round_shift(input logic [63:0] a, input logic [63:0] b,
                                                    input int unsigned sh);
        logic [128:0] prod;
        prod = {65'd0, a} * {65'd0, b};
        prod = prod + (129'd1 << (sh - 1));
        return 64'(prod >> sh);
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // signed fixed-point product, rounded half away from zero
    function automatic longint fixed_mul(input longint a, input longint b);
        logic [63:0] m;
        logic        neg;
        m   = mul_round_shift(magnitude(a), magnitude(b), FRAC);
        neg = (a < 0) != (b < 0);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint reciprocal(input int i);
        logic [63:0] one;
        one = 64'd1 << FRAC;
        return longint'((one + 64'(i / 2)) / 64'(i));
    endfunction

    function automatic phi_word_t phi_series(input logic [X_W-1:0] raw);
        int          x;
        longint      sq;
        longint      t;
        longint      one;
        longint      term;
        longint      sum;
        logic [63:0] e;
        logic [63:0] d;
        phi_word_t   r;
        x = int'($signed(raw));
        r.clamped = 1'b0;
        if (x > CLAMP_LIMIT) begin
            x = CLAMP_LIMIT;
            r.clamped = 1'b1;
        end
        if (x < -CLAMP_LIMIT) begin
            x = -CLAMP_LIMIT;
            r.clamped = 1'b1;
        end
        sq = longint'(x) * longint'(x);
        if (FRAC >= 25)
            t = -(sq <<< (FRAC - 25));
        else
            t = -((sq + (longint'(1) <<< (24 - FRAC))) >>> (25 - FRAC));
        one  = longint'(1) <<< FRAC;
        term = one;
        sum  = one;
        for (int i = 1; i < SERIES_TERMS; i++)
        begin
            term = fixed_mul(term, t);
            term = fixed_mul(term, reciprocal(i));
            sum  = sum + term;
        end
        if (sum < 0)
            e = 64'd0;
        else if (sum > one)
            e = 64'(one);
        else
            e = 64'(sum);
        d = mul_round_shift(e, ROOT_TWO_PI_INV, FRAC + 16);
        if (d > DENS_CEIL)
            d = DENS_CEIL;
        r.density = d[DENS_W-1:0];
        return r;
    endfunction

    function automatic logic [X_W-1:0] random_x();
        int unsigned sel;
        int          v;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            v = int'($urandom_range(0, 2 * CLAMP_LIMIT)) - CLAMP_LIMIT;
        else if (sel < 82)
            v = int'($urandom_range(0, 65535));
        else if (sel < 92)
        begin
            v = CLAMP_LIMIT + int'($urandom_range(0, 8)) - 4;
            if ($urandom_range(0, 1) == 1)
                v = -v;
        end
        else
            v = int'($urandom_range(0, 64)) - 32;
        return v[X_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input logic [X_W-1:0] x, input logic typed,
                             input logic [DENS_W-1:0] dens, input logic flag);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        x_in        = x;
        cur_typed   = typed;
        cur_density = dens;
        cur_clamped = flag;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        in_valid = 1'b0;
        while (phi_expected.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("gaussian_density_series_test: errors");
        $finish;
    end

    // receiver: random back-pressure plus long hold-offs on request
    initial
    begin
        out_ready   = 1'b0;
        hold_served = 0;
        hold_left   = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_asked != hold_served)
            begin
                hold_served = hold_asked;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got_word = '{density, clamped};
                if (phi_expected.size() == 0)
                    report_mismatch($sformatf("unexpected word density=%0d clamped=%0b",
                                              density, clamped));
                else
                begin
                    want_word = phi_expected.pop_front();
                    if (got_word.density !== want_word.density)
                        report_mismatch($sformatf("density %0d, expected %0d",
                                                  got_word.density, want_word.density));
                    if (got_word.clamped !== want_word.clamped)
                        report_mismatch($sformatf("clamped %0b, expected %0b",
                                                  got_word.clamped, want_word.clamped));
                end
            end
            if (in_valid && in_ready)
            begin
                if (cur_typed)
                    phi_expected.push_back('{cur_density, cur_clamped});
                else
                    phi_expected.push_back(phi_series(x_in));
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        x_in          = '0;
        cur_typed     = 1'b0;
        cur_density   = '0;
        cur_clamped   = 1'b0;
        hold_asked    = 0;
        error_count   = 0;
        send_idle_pct = 8;
        recv_idle_pct = 81;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].x, directed_rows[i].typed,
                      directed_rows[i].density, directed_rows[i].clamped);
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_word(random_x(), 1'b0, '0, 1'b0);
        wait_for_results();

        send_idle_pct = 81;
        recv_idle_pct = 8;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_word(random_x(), 1'b0, '0, 1'b0);
        wait_for_results();

        // no idling; long receiver hold-off fills the pipe while words keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asked++;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_word(random_x(), 1'b0, '0, 1'b0);
        wait_for_results();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0 && phi_expected.size() == 0)
            $display("gaussian_density_series_test: clean");
        else
            $display("gaussian_density_series_test: errors");
        $finish;
    end

endmodule
